// ----- rtl/core/ordered_list_insert_delete_engine_defines.svh -----
// ============================================================================
// Assertion macros for the ordered list engine
// Concurrent assertion wrappers that can be compiled out as one group.
// ============================================================================
`ifndef ORDERED_LIST_INSERT_DELETE_ENGINE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge, idle while reset is asserted.
`define OLIDE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define OLIDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define OLIDE_ASSERT(lbl, clk, rst_n, prop, msg)
`define OLIDE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/core/olide_pkg.sv -----
// ============================================================================
// olide_pkg
// Shared widths, opcodes and result type of the ordered list engine.
// ============================================================================
package olide_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned ELEM_W       = 32;
	localparam int unsigned OP_W         = 2;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE     = 2'd2;

	typedef struct packed {
		logic signed [ELEM_W-1:0] element;
		logic                     is_last;
		logic                     list_empty;
		logic                     push_dropped;
	} rsp_t;

endpackage

// ----- rtl/core/olide_req_if.sv -----
// ============================================================================
// olide_req_if
// Request channel: one list operation per request.
// ============================================================================
interface olide_req_if
	import olide_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic signed [ELEM_W-1:0] operand;

	modport source (output valid, output opcode, output operand, input ready);
	modport sink   (input valid, input opcode, input operand, output ready);
endinterface

// ----- rtl/core/olide_rsp_if.sv -----
// ============================================================================
// olide_rsp_if
// Result channel: one list element per transfer.
// ============================================================================
interface olide_rsp_if
	import olide_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] element;
	logic                     is_last;
	logic                     list_empty;
	logic                     push_dropped;

	modport source (output valid, output element, output is_last, output list_empty,
		output push_dropped, input ready);
	modport sink   (input valid, input element, input is_last, input list_empty,
		input push_dropped, output ready);
endinterface

// ----- rtl/core/ordered_list_insert_delete_engine.sv -----
// ============================================================================
// ordered_list_insert_delete_engine
// Ordered list of signed words with push front, push back and delete by
// position; every request is answered by a dump of the whole list.
// ============================================================================
// The list lives in one RAM used as a ring: a head pointer marks the front, so
// a push at either end is a single write. After each request the engine
// streams the list front to back, one element per cycle while the result
// buffer has room, through the RAM's single read port, and flags the final
// element; an empty list yields one result with list_empty set and a zero
// element. A delete is folded into that dump: elements past the deleted
// position are read one slot further on and written back one slot closer to
// the front as they pass, so a delete needs no pass of its own. A stalled
// result port stretches a dump. A new request is taken once the last read of
// the previous dump has returned from the RAM, while its last results may
// still wait in the two-entry output buffer. A push onto a full list leaves
// the list unchanged and sets push_dropped on every result of that dump. A
// delete position that is negative or not below the element count leaves the
// list unchanged. The RAM needs no clearing after reset: only entries that
// hold list elements are ever read.
// ============================================================================
`include "ordered_list_insert_delete_engine_defines.svh"

module ordered_list_insert_delete_engine
	import olide_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	olide_req_if.sink    req,
	olide_rsp_if.source  rsp
);
	localparam int unsigned AW    = $clog2(CAPACITY);
	localparam int unsigned DEPTH = 2 ** AW;
	localparam int unsigned CW    = $clog2(CAPACITY + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	// Control state.
	logic          state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          del_act_q;
	logic [CW-1:0] del_pos_q;
	logic          dropped_q;

	// Read stage: the RAM read issued last cycle.
	logic          rd_vld_s1;
	logic          last_s1;
	logic          empty_s1;
	logic          dropped_s1;
	logic          wb_en_s1;
	logic [AW-1:0] wb_addr_s1;

	// Output register and skid entry.
	logic out_vld_q;
	logic skid_vld_q;
	rsp_t out_q;
	rsp_t skid_q;
	rsp_t s1_rsp;

	// RAM ports.
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [ELEM_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [ELEM_W-1:0] ram_rdata;

	// Request decode.
	logic          req_fire;
	logic          list_full;
	logic          del_ok;
	logic          push_ok;
	logic          push_front;
	logic          push_drop;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] tail_addr;

	// Dump issue.
	logic          out_fire;
	logic [1:0]    occ;
	logic [1:0]    occ_next;
	logic          can_issue;
	logic          issue;
	logic          shift;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] rd_idx;
	logic          idx_last;

	olide_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A new request may only start once no delete write-back is pending, so
	// its own RAM write never collides with one.
	assign req.ready = (state_q == ST_IDLE) && !rd_vld_s1;
	assign req_fire  = req.valid && req.ready;

	assign list_full = (count_q >= CW'(CAPACITY));
	assign head_dec  = head_q - 1'b1;
	assign tail_addr = head_q + count_q[AW-1:0];

	always_comb begin
		push_ok    = 1'b0;
		push_front = 1'b0;
		push_drop  = 1'b0;
		del_ok     = 1'b0;
		case (req.opcode)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				push_ok    = !list_full;
				push_drop  = list_full;
				push_front = (req.opcode == OP_PUSH_FRONT);
			end
			OP_DELETE: begin
				// A negative position has its sign bit set and is out of range.
				del_ok = !req.operand[ELEM_W-1] &&
					({1'b0, req.operand[ELEM_W-2:0]} < ELEM_W'(count_q));
			end
			default: begin
			end
		endcase
	end

	// The result buffer holds two entries; a read is issued only when its data
	// is sure to find room once it returns from the RAM.
	assign out_fire  = out_vld_q && rsp.ready;
	assign occ       = {1'b0, rd_vld_s1} + {1'b0, out_vld_q} + {1'b0, skid_vld_q};
	assign occ_next  = occ - {1'b0, out_fire};
	assign can_issue = (occ_next < 2'd2);
	assign issue     = (state_q == ST_DUMP) && can_issue;

	// Past the deleted position each element comes from one slot further on.
	assign shift    = del_act_q && (idx_q >= del_pos_q);
	assign idx_inc  = CW'(idx_q + 1'b1);
	assign rd_idx   = shift ? idx_inc : idx_q;
	assign idx_last = (count_q == '0) || (idx_q == CW'(count_q - 1'b1));

	assign ram_re    = issue;
	assign ram_raddr = head_q + rd_idx[AW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wb_addr_s1;
		ram_wdata = ram_rdata;
		if (req_fire && push_ok) begin
			ram_we    = 1'b1;
			ram_waddr = push_front ? head_dec : tail_addr;
			ram_wdata = req.operand;
		end else if (wb_en_s1) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			del_act_q <= 1'b0;
			del_pos_q <= '0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q   <= ST_DUMP;
						idx_q     <= '0;
						dropped_q <= push_drop;
						del_act_q <= del_ok;
						del_pos_q <= req.operand[CW-1:0];
						if (push_ok) begin
							count_q <= CW'(count_q + 1'b1);
							if (push_front) begin
								head_q <= head_dec;
							end
						end else if (del_ok) begin
							count_q <= CW'(count_q - 1'b1);
						end
					end
				end
				ST_DUMP: begin
					if (issue) begin
						idx_q <= idx_inc;
						if (idx_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			wb_en_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			wb_en_s1  <= issue && shift;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1    <= idx_last;
			empty_s1   <= (count_q == '0);
			dropped_s1 <= dropped_q;
			wb_addr_s1 <= head_q + idx_q[AW-1:0];
		end
	end

	always_comb begin
		s1_rsp.element      = empty_s1 ? '0 : ram_rdata;
		s1_rsp.is_last      = last_s1;
		s1_rsp.list_empty   = empty_s1;
		s1_rsp.push_dropped = dropped_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || out_fire) begin
				if (skid_vld_q) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= rd_vld_s1;
				end else begin
					out_vld_q <= rd_vld_s1;
				end
			end else if (rd_vld_s1) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_fire) begin
			if (skid_vld_q) begin
				out_q  <= skid_q;
				skid_q <= s1_rsp;
			end else begin
				out_q <= s1_rsp;
			end
		end else if (rd_vld_s1) begin
			skid_q <= s1_rsp;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.element      = out_q.element;
	assign rsp.is_last      = out_q.is_last;
	assign rsp.list_empty   = out_q.list_empty;
	assign rsp.push_dropped = out_q.push_dropped;

	// The element count never passes the capacity.
	`OLIDE_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY), "list count above capacity")

	// Returning read data always finds room in the output buffer.
	`OLIDE_ASSERT(a_buffer_room, clk, arst_n, (rd_vld_s1 && out_vld_q && !out_fire) |-> !skid_vld_q, "result buffer overrun")

	// A request write never lands in the same cycle as a delete write-back.
	`OLIDE_ASSERT_ALWAYS(a_write_port, clk, req_fire |-> !wb_en_s1, "RAM write port conflict")

	// An empty-list result is a single, final result with a zero element.
	`OLIDE_ASSERT(a_empty_result, clk, arst_n, (rsp.valid && rsp.list_empty) |-> (rsp.is_last && rsp.element == '0), "malformed empty result")

	// A dump ends in the idle state right after its final read is issued.
	`OLIDE_ASSERT(a_dump_end, clk, arst_n, (issue && idx_last) |=> (state_q == ST_IDLE && last_s1), "dump did not end on last read")
endmodule

// ----- rtl/core/olide_ram.sv -----
// ============================================================================
// olide_ram
// Simple dual-port RAM, one write and one registered read port.
// ============================================================================
module olide_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- sim/ordered_list_dump_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ordered_list_dump_checker
// Watches the request and result channels of the ordered list engine, keeps
// its own copy of the list, and compares every list dump it sees.
// ============================================================================
module ordered_list_dump_checker
	import olide_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	olide_req_if  req,
	olide_rsp_if  rsp,
	output int    fail_count,
	output int    outstanding
);

	localparam int unsigned REPORT_LIMIT = 10;

	logic signed [ELEM_W-1:0] list_slots [CAPACITY];
	int unsigned              list_len = 0;
	rsp_t                     expected_dump [$];

	initial fail_count = 0;

	task automatic note_failure(input string what);
		if (fail_count < REPORT_LIMIT)
			$display("%0t ns: %s", $time, what);
		fail_count++;
	endtask

	// Applies one request to the list copy and queues the dump it causes.
	function automatic void apply_request(input logic [OP_W-1:0] opcode,
		input logic signed [ELEM_W-1:0] operand);
		logic        dropped;
		int unsigned k;
		rsp_t        item;
		dropped = 1'b0;
		case (opcode)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (list_len >= CAPACITY) begin
					dropped = 1'b1;
				end else if (opcode == OP_PUSH_FRONT) begin
					for (k = list_len; k > 0; k--)
						list_slots[k] = list_slots[k - 1];
					list_slots[0] = operand;
					list_len++;
				end else begin
					list_slots[list_len] = operand;
					list_len++;
				end
			end
			OP_DELETE: begin
				// A negative position has its sign bit set and never matches.
				if (!operand[ELEM_W-1] && unsigned'(operand) < list_len) begin
					for (k = unsigned'(operand); k + 1 < list_len; k++)
						list_slots[k] = list_slots[k + 1];
					list_len--;
				end
			end
			default: ;
		endcase
		if (list_len == 0) begin
			item.element      = '0;
			item.is_last      = 1'b1;
			item.list_empty   = 1'b1;
			item.push_dropped = dropped;
			expected_dump.push_back(item);
		end else begin
			for (k = 0; k < list_len; k++) begin
				item.element      = list_slots[k];
				item.is_last      = (k + 1 == list_len);
				item.list_empty   = 1'b0;
				item.push_dropped = dropped;
				expected_dump.push_back(item);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t seen;
		rsp_t want;
		if (!arst_n) begin
			list_len = 0;
			expected_dump.delete();
			outstanding <= 0;
		end else begin
			// Results are taken first; a request accepted at this edge cannot
			// have produced any of them yet.
			if (rsp.valid && rsp.ready) begin
				seen.element      = rsp.element;
				seen.is_last      = rsp.is_last;
				seen.list_empty   = rsp.list_empty;
				seen.push_dropped = rsp.push_dropped;
				if (expected_dump.size() == 0) begin
					note_failure($sformatf("result with none expected: element %0d last %b empty %b dropped %b",
						seen.element, seen.is_last, seen.list_empty, seen.push_dropped));
				end else begin
					want = expected_dump.pop_front();
					if (seen.element !== want.element || seen.is_last !== want.is_last ||
						seen.list_empty !== want.list_empty ||
						seen.push_dropped !== want.push_dropped)
						note_failure($sformatf({"result mismatch: expected element %0d last %b ",
							"empty %b dropped %b, got element %0d last %b empty %b dropped %b"},
							want.element, want.is_last, want.list_empty, want.push_dropped,
							seen.element, seen.is_last, seen.list_empty, seen.push_dropped));
				end
			end
			if (req.valid && req.ready)
				apply_request(req.opcode, req.operand);
			outstanding <= expected_dump.size();
		end
	end

endmodule

// ----- sim/ordered_list_insert_delete_engine_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ordered_list_insert_delete_engine_test
// Drives push-front, push-back and delete requests into the ordered list
// engine under random backpressure and gaps; a checker beside the engine
// predicts every list dump and counts disagreements.
// ============================================================================
module ordered_list_insert_delete_engine_test;
	import olide_pkg::*;

	localparam int unsigned CAPACITY     = CAPACITY_DEF;
	// Number of counted requests in the random part of the run.
	localparam int unsigned RANDOM_ITEMS = 450;
	// The last requests of the run go through with no gaps and no stalls.
	localparam int unsigned CALM_ITEMS   = 60;
	// Even a full dump with the longest stall on every result, for every
	// request, keeps the run far below this.
	localparam int unsigned CYCLE_LIMIT  = 1_500_000;
	// Once nothing is expected, wait a little longer than one full dump so
	// that any stray result still shows up.
	localparam int unsigned DRAIN_CYCLES = CAPACITY + 16;
	// Opcode with no meaning: the engine leaves the list alone and dumps it.
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

	// Request mix for one stretch of random traffic.
	typedef enum int unsigned {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_t;

	logic clk = 1'b0;
	logic arst_n;

	olide_req_if req_ch ();
	olide_rsp_if rsp_ch ();

	int fail_count;
	int outstanding;

	// Length of the list as the stimulus sees it; used only to aim delete
	// positions and to know when the list is full.
	int unsigned stim_len = 0;
	// Counted requests in the random part; reserved opcodes are not counted.
	int unsigned requests_sent = 0;
	// Set for the final stretch of the run, where neither side idles.
	logic calm = 1'b0;
	// Whether the sender inserts gaps during the current stretch.
	bit gaps_on = 1'b0;
	int unsigned cycle_count = 0;

	always #5 clk = ~clk;

	ordered_list_insert_delete_engine #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	ordered_list_dump_checker #(
		.CAPACITY(CAPACITY)
	) dump_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	// Hard stop in case the engine hangs or the run never drains.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[ordered_list_insert_delete_engine] ERROR");
			$finish;
		end
	end

	// Result side: stalls come in bursts. Each long stretch either stalls now
	// and then or never stalls, and the final stretch of the run never stalls.
	initial begin
		int unsigned hold;
		int unsigned stretch_left;
		bit          stalls_on;
		hold         = 0;
		stretch_left = 0;
		stalls_on    = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stretch_left == 0) begin
				stalls_on    = $urandom_range(0, 2) != 0;
				stretch_left = $urandom_range(50, 300);
			end
			stretch_left--;
			if (hold != 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && stalls_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 9) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Presents one request and returns at the edge where it is accepted,
	// with valid still high so that a following request can go straight on.
	task automatic send_request(input logic [OP_W-1:0] op,
		input logic signed [ELEM_W-1:0] arg);
		req_ch.opcode  <= op;
		req_ch.operand <= arg;
		req_ch.valid   <= 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (stim_len < CAPACITY)
					stim_len++;
			end
			OP_DELETE: begin
				if (!arg[ELEM_W-1] && unsigned'(arg) < stim_len)
					stim_len--;
			end
			default: ;
		endcase
		if (op != OP_RESERVED)
			requests_sent++;
	endtask

	task automatic idle_sender(input int unsigned cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Values to push: the extremes now and then, any word otherwise.
	function automatic logic signed [ELEM_W-1:0] random_word();
		case ($urandom_range(0, 15))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return 32'shFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Delete positions: mostly inside the list, the rest just past its end,
	// negative, or anywhere at all.
	function automatic logic signed [ELEM_W-1:0] delete_position();
		case ($urandom_range(0, 9))
			0:       return stim_len + $urandom_range(0, 3);
			1:       return 32'shFFFF_FFFF - $urandom_range(0, 3);
			2:       return $urandom;
			3:       return 32'sh8000_0000;
			default: begin
				if (stim_len != 0)
					return $urandom_range(0, stim_len - 1);
				return $urandom_range(0, 3);
			end
		endcase
	endfunction

	// One random request, with an optional gap before it.
	task automatic random_item(input mix_t mix);
		int unsigned push_pct;
		logic [OP_W-1:0] op;
		logic signed [ELEM_W-1:0] arg;
		push_pct = (mix == MIX_GROW) ? 80 : (mix == MIX_SHRINK) ? 20 : 50;
		if (RANDOM_ITEMS - requests_sent <= CALM_ITEMS)
			calm <= 1'b1;
		else if (gaps_on && $urandom_range(0, 3) == 0)
			idle_sender($urandom_range(1, 9));
		if ($urandom_range(0, 39) == 0) begin
			op  = OP_RESERVED;
			arg = $urandom;
		end else if ($urandom_range(1, 100) <= push_pct) begin
			op  = ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			arg = random_word();
		end else begin
			op  = OP_DELETE;
			arg = delete_position();
		end
		send_request(op, arg);
	endtask

	initial begin
		mix_t        mix;
		int unsigned stretch;
		req_ch.valid   <= 1'b0;
		req_ch.opcode  <= OP_PUSH_FRONT;
		req_ch.operand <= '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An empty list first: deletes at any position and
		// the reserved opcode must all leave it empty.
		send_request(OP_DELETE, 32'sd0);
		send_request(OP_DELETE, 32'shFFFF_FFFF);
		send_request(OP_RESERVED, 32'sd0);
		// Both extremes of the value range, one at each end of the list.
		send_request(OP_PUSH_BACK, 32'sh8000_0000);
		send_request(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
		send_request(OP_PUSH_BACK, 32'shFFFF_FFFF);
		send_request(OP_PUSH_FRONT, 32'sd0);
		send_request(OP_PUSH_BACK, 32'sd1);
		// Positions out of range: exactly the count, minus one, the most
		// negative and the largest positive word.
		send_request(OP_DELETE, 32'sd5);
		send_request(OP_DELETE, 32'shFFFF_FFFF);
		send_request(OP_DELETE, 32'sh8000_0000);
		send_request(OP_DELETE, 32'sh7FFF_FFFF);
		send_request(OP_RESERVED, 32'sh1234_5678);
		// In-range deletes from the middle, the back and the front, down to
		// an empty list again.
		send_request(OP_DELETE, 32'sd2);
		send_request(OP_DELETE, 32'sd3);
		send_request(OP_DELETE, 32'sd0);
		send_request(OP_DELETE, 32'sd1);
		send_request(OP_DELETE, 32'sd0);
		send_request(OP_PUSH_FRONT, 32'sh5555_5555);
		send_request(OP_PUSH_BACK, 32'shAAAA_AAAA);

		// Hold off until the engine has answered everything so far. The
		// count seen here is registered, so let it catch up before looking.
		idle_sender(1);
		while (outstanding != 0)
			@(posedge clk);

		// Random part. It opens by filling the list to capacity, then pushes
		// at both ends of the full list, which must be refused.
		requests_sent = 0;
		gaps_on = 1'b1;
		while (stim_len < CAPACITY)
			random_item(MIX_GROW);
		send_request(OP_PUSH_FRONT, random_word());
		send_request(OP_PUSH_BACK, random_word());

		// Then stretches of mixed traffic, each leaning toward growing,
		// shrinking or neither, with gaps switched on or off per stretch.
		while (requests_sent < RANDOM_ITEMS) begin
			mix     = mix_t'($urandom_range(0, 2));
			gaps_on = $urandom_range(0, 2) != 0;
			stretch = $urandom_range(20, 60);
			while (stretch != 0 && requests_sent < RANDOM_ITEMS) begin
				random_item(mix);
				stretch--;
			end
		end

		// Wind down: let every expected result arrive, then give the engine
		// time to show anything it should not send.
		idle_sender(1);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("[ordered_list_insert_delete_engine] OK");
		else
			$display("[ordered_list_insert_delete_engine] ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/olide_pkg.sv
rtl/core/olide_req_if.sv
rtl/core/olide_rsp_if.sv
rtl/core/olide_ram.sv
rtl/core/ordered_list_insert_delete_engine.sv
sim/ordered_list_dump_checker.sv
sim/ordered_list_insert_delete_engine_test.sv
